/* rtl/vuln_pkg.sv */
// shared widths, step counts and defaults for the vector length normaliser
package vuln_pkg;

    // payload widths
    localparam int TAG_W   = 16;
    localparam int VALUE_W = 16;
    localparam int THR_W   = 16;
    localparam int ENTRY_W = TAG_W + VALUE_W;

    // fractional bits of the q4.12 format
    localparam int FRAC_W = 12;

    // running sum of squares and its integer square root
    localparam int SUM_W      = 37;
    localparam int NORM_W     = 19;
    localparam int ROOT_STEPS = 19;
    localparam int ROOT_CNT_W = 5;

    // the norm is never below any stored magnitude, so the quotient stays under 2^13
    localparam int QUOT_W     = 14;
    localparam int QUOT_CNT_W = 4;

    // default capacity and threshold
    localparam int              MAX_ELEMENTS_DEF = 64;
    localparam logic [THR_W-1:0] THR_RESET       = 16'd1;

endpackage

/* rtl/vector_unit_length_normalizer.sv */
// top level: l2 normalisation of a sparse vector held in an element ram
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------------
//  element  | start, busy (taken at      | element_tag, element_value, last_element
//           | start & !busy)             |
//  result   | result_valid, one cycle    | result_tag, result_value, result_last,
//           |                            | overflowed
//  config   | cfg_valid, cfg_ready       | cfg_data (norm threshold)
//
// elements are taken one per cycle while collecting; the last one raises busy.
// closing a vector passes through the settle and root start states, then the bit-pair
// square root unit (19 steps and a done strobe).
// each result is then read from ram through the read and load states; when the norm is
// above the threshold, the serial divider (one quotient bit per cycle, 14 bits) scales it.
// no clearing pass after reset; the receiver cannot stall results.
module vector_unit_length_normalizer #(
    parameter int MAX_ELEMENTS = vuln_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [vuln_pkg::TAG_W-1:0]          element_tag,
    input  logic signed [vuln_pkg::VALUE_W-1:0] element_value,
    input  logic                                last_element,
    output logic                                result_valid,
    output logic [vuln_pkg::TAG_W-1:0]          result_tag,
    output logic signed [vuln_pkg::VALUE_W-1:0] result_value,
    output logic                                result_last,
    output logic                                overflowed,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [vuln_pkg::THR_W-1:0]          cfg_data
);

    localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int VW = vuln_pkg::VALUE_W;
    localparam int TW = vuln_pkg::TAG_W;
    localparam int NW = vuln_pkg::NORM_W;
    localparam int SQ_W = 2 * VW;

    typedef enum logic [6:0] {
        S_COLLECT = 7'b0000001,
        S_SETTLE  = 7'b0000010,
        S_ROOT_GO = 7'b0000100,
        S_ROOT    = 7'b0001000,
        S_READ    = 7'b0010000,
        S_LOAD    = 7'b0100000,
        S_DIV     = 7'b1000000
    } state_t;

    state_t                       state_reg;
    state_t                       state_next;
    logic [vuln_pkg::THR_W-1:0]   thr_reg;
    logic [CW-1:0]                count_reg;
    logic [CW-1:0]                idx_reg;
    logic                         ovf_reg;
    logic [vuln_pkg::SUM_W-1:0]   sum_reg;
    logic [SQ_W-1:0]              sq_reg;
    logic                         sq_pend_reg;
    logic [NW-1:0]                norm_reg;
    logic                         scale_reg;
    logic                         neg_reg;
    logic [TW-1:0]                tag_reg;
    logic                         result_valid_reg;
    logic [TW-1:0]                result_tag_reg;
    logic [VW-1:0]                result_value_reg;
    logic                         result_last_reg;
    logic                         overflowed_reg;

    logic                         accept;
    logic                         store_en;
    logic [vuln_pkg::ENTRY_W-1:0] rd_data;
    logic [VW-1:0]                rd_value;
    logic [VW-1:0]                rd_mag;
    logic                         root_done;
    logic [NW-1:0]                root_val;
    logic                         div_start;
    logic                         div_done;
    logic [vuln_pkg::QUOT_W-1:0]  quot;
    logic [VW-1:0]                quot_ext;
    logic [VW-1:0]                scaled;
    logic                         emit;
    logic [VW-1:0]                emit_value;
    logic                         at_end;
    logic signed [SQ_W-1:0]       square;

    // request handshake and element store
    always_comb
    begin
        accept   = start && (state_reg == S_COLLECT);
        store_en = accept && (count_reg < CW'(MAX_ELEMENTS));
        square   = element_value * element_value;
        rd_value = rd_data[VW-1:0];
        rd_mag   = rd_value[VW-1] ? (~rd_value + 1'b1) : rd_value;
        quot_ext = VW'(quot);
        scaled   = neg_reg ? (~quot_ext + 1'b1) : quot_ext;
        at_end   = ((idx_reg + 1'b1) == count_reg);
        div_start = (state_reg == S_LOAD) && scale_reg;
        emit     = ((state_reg == S_LOAD) && !scale_reg) || ((state_reg == S_DIV) && div_done);
        emit_value = (state_reg == S_DIV) ? scaled : rd_value;
    end

    vuln_ram #(
        .WIDTH  (vuln_pkg::ENTRY_W),
        .DEPTH  (MAX_ELEMENTS),
        .ADDR_W (AW)
    ) u_store (
        .clk   (clk),
        .we    (store_en),
        .waddr (count_reg[AW-1:0]),
        .wdata ({element_tag, element_value}),
        .raddr (idx_reg[AW-1:0]),
        .rdata (rd_data)
    );

    vuln_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_ROOT_GO),
        .radicand (sum_reg),
        .done     (root_done),
        .root     (root_val)
    );

    vuln_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .mag      (rd_mag),
        .divisor  (norm_reg),
        .done     (div_done),
        .quotient (quot)
    );

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_COLLECT: if (accept && last_element) state_next = S_SETTLE;
            S_SETTLE:  state_next = S_ROOT_GO;
            S_ROOT_GO: state_next = S_ROOT;
            S_ROOT:    if (root_done) state_next = S_READ;
            S_READ:    state_next = S_LOAD;
            S_LOAD:
            begin
                if (scale_reg)
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = at_end ? S_COLLECT : S_READ;
                end
            end
            S_DIV:     if (div_done) state_next = at_end ? S_COLLECT : S_READ;
            default:   state_next = S_COLLECT;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_COLLECT;
            thr_reg          <= vuln_pkg::THR_RESET;
            count_reg        <= '0;
            idx_reg          <= '0;
            ovf_reg          <= 1'b0;
            sum_reg          <= '0;
            sq_pend_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= emit;
            sq_pend_reg      <= store_en;

            if (cfg_valid && cfg_ready)
            begin
                thr_reg <= cfg_data;
            end

            // element count and overflow
            if (store_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (accept && !store_en)
            begin
                ovf_reg <= 1'b1;
            end

            // result index
            if (state_reg == S_ROOT)
            begin
                idx_reg <= '0;
            end
            else if (emit)
            begin
                idx_reg <= idx_reg + 1'b1;
            end

            // sum of squares, cleared when the vector is done
            if (emit && at_end)
            begin
                sum_reg   <= '0;
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            else if (sq_pend_reg)
            begin
                sum_reg <= sum_reg + vuln_pkg::SUM_W'(sq_reg);
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            sq_reg <= unsigned'(square);
        end
        if ((state_reg == S_ROOT) && root_done)
        begin
            norm_reg  <= root_val;
            scale_reg <= (root_val > NW'(thr_reg));
        end
        if (state_reg == S_LOAD)
        begin
            tag_reg <= rd_data[vuln_pkg::ENTRY_W-1:VW];
            neg_reg <= rd_value[VW-1];
        end
        if (emit)
        begin
            result_tag_reg   <= (state_reg == S_DIV) ? tag_reg : rd_data[vuln_pkg::ENTRY_W-1:VW];
            result_value_reg <= emit_value;
            result_last_reg  <= at_end;
            overflowed_reg   <= ovf_reg;
        end
    end

    assign busy         = (state_reg != S_COLLECT);
    assign cfg_ready    = (state_reg == S_COLLECT);
    assign result_valid = result_valid_reg;
    assign result_tag   = result_tag_reg;
    assign result_value = signed'(result_value_reg);
    assign result_last  = result_last_reg;
    assign overflowed   = overflowed_reg;

endmodule

/* rtl/vuln_ram.sv */
// generic single write port, single read port ram with registered read
module vuln_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/vuln_sqrt.sv */
// iterative integer square root, two radicand bits per cycle
module vuln_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [vuln_pkg::SUM_W-1:0]  radicand,
    output logic                        done,
    output logic [vuln_pkg::NORM_W-1:0] root
);

    localparam int NW = vuln_pkg::NORM_W;
    localparam int RW = NW + 3;

    logic [2*NW-1:0]                   x_reg;
    logic [RW-1:0]                     rem_reg;
    logic [NW-1:0]                     root_reg;
    logic [vuln_pkg::ROOT_CNT_W-1:0]   cnt_reg;
    logic                              active_reg;
    logic                              done_reg;

    logic [RW-1:0] rem_shift;
    logic [RW-1:0] trial;
    logic          fits;

    // one restoring step: bring down two bits, try root*4+1
    always_comb
    begin
        rem_shift = {rem_reg[NW:0], x_reg[2*NW-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        fits      = (rem_shift >= trial);
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                active_reg <= 1'b1;
                cnt_reg    <= vuln_pkg::ROOT_CNT_W'(vuln_pkg::ROOT_STEPS);
            end
            else if (active_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == vuln_pkg::ROOT_CNT_W'(1))
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= (2*NW)'(radicand);
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (active_reg)
        begin
            x_reg    <= {x_reg[2*NW-3:0], 2'b00};
            rem_reg  <= fits ? (rem_shift - trial) : rem_shift;
            root_reg <= {root_reg[NW-2:0], fits};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

/* rtl/vuln_div.sv */
// restoring divider, one quotient bit per cycle: (mag << 12) / divisor
module vuln_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [vuln_pkg::VALUE_W-1:0] mag,
    input  logic [vuln_pkg::NORM_W-1:0]  divisor,
    output logic                         done,
    output logic [vuln_pkg::QUOT_W-1:0]  quotient
);

    localparam int NW = vuln_pkg::NORM_W;
    localparam int QW = vuln_pkg::QUOT_W;
    localparam int DW = vuln_pkg::VALUE_W + vuln_pkg::FRAC_W;

    logic [NW:0]                       rem_reg;
    logic [QW-1:0]                     low_reg;
    logic [QW-1:0]                     q_reg;
    logic [NW-1:0]                     div_reg;
    logic [vuln_pkg::QUOT_CNT_W-1:0]   cnt_reg;
    logic                              active_reg;
    logic                              done_reg;

    logic [DW-1:0] dvd;
    logic [NW:0]   rem_shift;
    logic          fits;

    // dividend and one trial subtraction
    always_comb
    begin
        dvd       = {mag, {vuln_pkg::FRAC_W{1'b0}}};
        rem_shift = {rem_reg[NW-1:0], low_reg[QW-1]};
        fits      = (rem_shift >= {1'b0, div_reg});
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                active_reg <= 1'b1;
                cnt_reg    <= vuln_pkg::QUOT_CNT_W'(QW);
            end
            else if (active_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == vuln_pkg::QUOT_CNT_W'(1))
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    // datapath; upper dividend bits are below the divisor, so only low bits are iterated
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= (NW+1)'(dvd[DW-1:QW]);
            low_reg <= dvd[QW-1:0];
            q_reg   <= '0;
            div_reg <= divisor;
        end
        else if (active_reg)
        begin
            rem_reg <= fits ? (rem_shift - {1'b0, div_reg}) : rem_shift;
            low_reg <= {low_reg[QW-2:0], 1'b0};
            q_reg   <= {q_reg[QW-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

/* rtl/vuln_checker.sv */
// port level checks for the vector length normaliser, bound to the top level
module vuln_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic last_element,
    input logic result_valid,
    input logic result_last,
    input logic cfg_ready
);

    // a request marked last closes the vector and raises busy
    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && last_element) |=> busy)
        else $error("busy not raised after last element request");

    // results other than the final one come while still busy
    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_last) |-> busy)
        else $error("non-final result while idle");

    // each result needs a fresh ram read, so strobes never come back to back
    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobes back to back");

    // threshold only writable while idle
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> !busy)
        else $error("config ready while busy");

endmodule

bind vector_unit_length_normalizer vuln_checker u_vuln_checker (.*);
